>>> design/btf_pkg.sv
// ----------------------------------------------------------------------------
// btf_pkg
// Shared types and constants of the back-to-front depth sorter.
// ----------------------------------------------------------------------------
package btf_pkg;

	localparam int ID_W   = 16;
	localparam int POS_W  = 16;
	localparam int DIST_W = 34;
	localparam int CFG_W  = 2;

	localparam logic [CFG_W-1:0] REG_CAMERA_X = 2'd0;
	localparam logic [CFG_W-1:0] REG_CAMERA_Y = 2'd1;
	localparam logic [CFG_W-1:0] REG_CAMERA_Z = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] sq_dist;
		logic              last;
	} btf_word_t;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_DRAIN
	} btf_state_t;

endpackage

>>> design/back_to_front_depth_sorter.sv
// ----------------------------------------------------------------------------
// back_to_front_depth_sorter
// Painter's depth sort of transparent items, farthest first.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one item per cycle unless stalled:
// id, Q8.8 position and last_in. A two-stage front computes squared distance
// to the camera, a two-word queue decouples it from the insertion chain, and
// the chain places one item per cycle in its sorted slot while filling, ties
// in arrival order. An item reaches its slot through the front stages and the
// queue. After the item marked last, the chain drains one word per cycle on
// the output channel (out_valid/out_stall) while not stalled, farthest first;
// the final word carries last_out and overflowed. Input stalls during the
// drain once the queue and front are full. Items beyond MAX_ITEMS are dropped.
// A stalled output holds its word. Reset empties the chain and clears the
// camera registers; config writes (cfg_valid/cfg_ready) are always taken.
// ----------------------------------------------------------------------------
module back_to_front_depth_sorter #(
	parameter int MAX_ITEMS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] item_id,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	input  logic [15:0] pos_z,
	input  logic        last_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] out_id,
	output logic [33:0] sq_distance,
	output logic        last_out,
	output logic        overflowed
);

	logic [15:0]        cam_x_q, cam_y_q, cam_z_q;
	logic               fq_valid, fq_stall, bq_valid, bq_stall;
	btf_pkg::btf_word_t fq_word, bq_word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				btf_pkg::REG_CAMERA_X: cam_x_q <= cfg_data;
				btf_pkg::REG_CAMERA_Y: cam_y_q <= cfg_data;
				btf_pkg::REG_CAMERA_Z: cam_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	btf_front u_front (
		.clk(clk), .arst_n(arst_n),
		.camera_x(cam_x_q), .camera_y(cam_y_q), .camera_z(cam_z_q),
		.in_valid(in_valid), .in_stall(in_stall),
		.item_id(item_id), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.last_in(last_in),
		.q_valid(fq_valid), .q_stall(fq_stall), .q_word(fq_word)
	);

	btf_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fq_valid), .wr_stall(fq_stall), .wr_word(fq_word),
		.rd_valid(bq_valid), .rd_stall(bq_stall), .rd_word(bq_word)
	);

	btf_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(bq_valid), .q_stall(bq_stall), .q_word(bq_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_id(out_id), .sq_distance(sq_distance),
		.last_out(last_out), .overflowed(overflowed)
	);

endmodule

>>> design/btf_front.sv
// ----------------------------------------------------------------------------
// btf_front
// Accept items and compute squared distance to the camera in two stages.
// ----------------------------------------------------------------------------
module btf_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [15:0]               camera_x,
	input  logic [15:0]               camera_y,
	input  logic [15:0]               camera_z,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [btf_pkg::ID_W-1:0]  item_id,
	input  logic [btf_pkg::POS_W-1:0] pos_x,
	input  logic [btf_pkg::POS_W-1:0] pos_y,
	input  logic [btf_pkg::POS_W-1:0] pos_z,
	input  logic                      last_in,
	output logic                      q_valid,
	input  logic                      q_stall,
	output btf_pkg::btf_word_t        q_word
);

	logic               v_s1, v_s2;
	logic [15:0]        id_s1;
	logic               last_s1;
	logic signed [16:0] dx_s1, dy_s1, dz_s1;
	logic [33:0]        sx_s2, sy_s2, sz_s2;
	logic [15:0]        id_s2;
	logic               last_s2;
	logic               adv2, adv1;
	logic [16:0]        ax, ay, az;

	assign adv2     = !v_s2 || !q_stall;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1;

	assign ax = dx_s1[16] ? 17'(-dx_s1) : dx_s1;
	assign ay = dy_s1[16] ? 17'(-dy_s1) : dy_s1;
	assign az = dz_s1[16] ? 17'(-dz_s1) : dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= in_valid;
			if (adv2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			id_s1   <= item_id;
			last_s1 <= last_in;
			dx_s1   <= 17'($signed(pos_x)) - 17'($signed(camera_x));
			dy_s1   <= 17'($signed(pos_y)) - 17'($signed(camera_y));
			dz_s1   <= 17'($signed(pos_z)) - 17'($signed(camera_z));
		end
		if (adv2) begin
			id_s2   <= id_s1;
			last_s2 <= last_s1;
			sx_s2   <= 34'(ax * ax);
			sy_s2   <= 34'(ay * ay);
			sz_s2   <= 34'(az * az);
		end
	end

	assign q_valid        = v_s2;
	assign q_word.id      = id_s2;
	assign q_word.sq_dist = sx_s2 + sy_s2 + sz_s2;
	assign q_word.last    = last_s2;

endmodule

>>> design/btf_queue.sv
// ----------------------------------------------------------------------------
// btf_queue
// Two-entry queue between the distance front and the sorting back.
// ----------------------------------------------------------------------------
module btf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	output logic               wr_stall,
	input  btf_pkg::btf_word_t wr_word,
	output logic               rd_valid,
	input  logic               rd_stall,
	output btf_pkg::btf_word_t rd_word
);

	btf_pkg::btf_word_t mem_q [2];
	logic               wp_q, rp_q;
	logic [1:0]         cnt_q;
	logic               push, pop;

	assign wr_stall = cnt_q == 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_word  = mem_q[rp_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_word;
	end

endmodule

>>> design/btf_back.sv
// ----------------------------------------------------------------------------
// btf_back
// Systolic insertion chain; drains farthest first after the last item.
// ----------------------------------------------------------------------------
module btf_back #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	output logic                        q_stall,
	input  btf_pkg::btf_word_t          q_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [btf_pkg::ID_W-1:0]    out_id,
	output logic [btf_pkg::DIST_W-1:0]  sq_distance,
	output logic                        last_out,
	output logic                        overflowed
);

	localparam int CW = $clog2(MAX_ITEMS + 1);

	btf_pkg::btf_state_t state_q, state_d;
	logic [btf_pkg::ID_W-1:0]   id_q   [MAX_ITEMS];
	logic [btf_pkg::DIST_W-1:0] dist_q [MAX_ITEMS];
	logic [CW-1:0]              cnt_q, cnt_d;
	logic                       drop_q, drop_d;
	logic                       ins, shift_out;
	logic [MAX_ITEMS-1:0]       gt;

	// a slot is "below" the new item when it holds a valid, strictly nearer entry
	always_comb begin
		for (int i = 0; i < MAX_ITEMS; i++)
			gt[i] = (CW'(i) < cnt_q) && (dist_q[i] < q_word.sq_dist);
	end

	assign out_valid   = state_q == btf_pkg::ST_DRAIN;
	assign out_id      = id_q[0];
	assign sq_distance = dist_q[0];
	assign last_out    = cnt_q == CW'(1);
	assign overflowed  = last_out && drop_q;
	assign shift_out   = out_valid && !out_stall;
	assign q_stall     = state_q != btf_pkg::ST_FILL;
	assign ins         = q_valid && !q_stall;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		drop_d  = drop_q;
		case (state_q)
			btf_pkg::ST_FILL: begin
				if (ins) begin
					if (cnt_q == CW'(MAX_ITEMS))
						drop_d = 1'b1;
					else
						cnt_d = cnt_q + CW'(1);
					if (q_word.last) begin
						if (cnt_d == '0)
							drop_d = 1'b0;
						else
							state_d = btf_pkg::ST_DRAIN;
					end
				end
			end
			btf_pkg::ST_DRAIN: begin
				if (shift_out) begin
					cnt_d = cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						drop_d  = 1'b0;
						state_d = btf_pkg::ST_FILL;
					end
				end
			end
			default: state_d = btf_pkg::ST_FILL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btf_pkg::ST_FILL;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			drop_q  <= drop_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			if (shift_out) begin
				if (i < MAX_ITEMS - 1) begin
					id_q[i]   <= id_q[i+1];
					dist_q[i] <= dist_q[i+1];
				end
			end else if (ins && cnt_q != CW'(MAX_ITEMS)) begin
				if (gt[i]) begin
					if (i < MAX_ITEMS - 1) begin
						id_q[i+1]   <= id_q[i];
						dist_q[i+1] <= dist_q[i];
					end
					if (i == 0 || !gt[(i == 0) ? 0 : i-1]) begin
						id_q[i]   <= q_word.id;
						dist_q[i] <= q_word.sq_dist;
					end
				end else if (CW'(i) == cnt_q && (i == 0 || !gt[(i == 0) ? 0 : i-1])) begin
					id_q[i]   <= q_word.id;
					dist_q[i] <= q_word.sq_dist;
				end
			end
		end
	end

endmodule
